// ===== hdl/ialu_pkg.sv =====
// Shared types and constants for the integer operator unit.
package ialu_pkg;

  localparam int DW         = 64;
  localparam int WW         = 7;
  localparam int SHW        = 6;
  localparam int MAX_WIDTH_D = 64;
  localparam int QDEPTH     = 2;

  typedef enum logic [4:0] {
    F_PLUS  = 5'd0,  F_MINUS = 5'd1,  F_LNOT  = 5'd2,  F_BNOT  = 5'd3,
    F_RAND  = 5'd4,  F_RNAND = 5'd5,  F_ROR   = 5'd6,  F_RNOR  = 5'd7,
    F_RXOR  = 5'd8,  F_RXNOR = 5'd9,
    F_ADD   = 5'd10, F_SUB   = 5'd11, F_MUL   = 5'd12, F_DIV   = 5'd13,
    F_MOD   = 5'd14,
    F_EQ    = 5'd15, F_NE    = 5'd16, F_LT    = 5'd17, F_LE    = 5'd18,
    F_GT    = 5'd19, F_GE    = 5'd20,
    F_AND   = 5'd21, F_OR    = 5'd22, F_XOR   = 5'd23, F_XNOR  = 5'd24,
    F_LAND  = 5'd25, F_LOR   = 5'd26,
    F_SHL   = 5'd27, F_LSR   = 5'd28, F_ASR   = 5'd29
  } func_t;

  // classified item handed from front to back
  typedef struct packed {
    func_t           op;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    logic [DW-1:0]   sa;
    logic [DW-1:0]   sb;
    logic [DW-1:0]   m;
    logic            sg;
    logic            rhs_nz;
    logic            amt_big;
    logic [SHW-1:0]  sh;
  } q_item_t;

endpackage

// ===== hdl/ialu_if.sv =====
// Channel interfaces for operator beats and result beats.
interface ialu_in_if import ialu_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [4:0]    func;
  logic [DW-1:0] lhs_value;
  logic [DW-1:0] rhs_value;
  logic [WW-1:0] width;
  logic          signed_mode;
  modport source (output valid, func, lhs_value, rhs_value, width, signed_mode,
                  input ready);
  modport sink (input valid, func, lhs_value, rhs_value, width, signed_mode,
                output ready);
endinterface

interface ialu_out_if import ialu_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] result;
  logic          is_one_bit;
  modport source (output valid, result, is_one_bit, input ready);
  modport sink (input valid, result, is_one_bit, output ready);
endinterface

// ===== hdl/ialu_front.sv =====
// Front stage: normalizes width, masks and sign-extends operands, registers the item.
module ialu_front import ialu_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [4:0]    in_func,
  input  logic [DW-1:0] in_lhs,
  input  logic [DW-1:0] in_rhs,
  input  logic [WW-1:0] in_width,
  input  logic          in_signed,
  output logic          fq_valid,
  input  logic          fq_ready,
  output q_item_t       fq_item
);

  logic            v_r;
  q_item_t         item_r;
  q_item_t         item_c;
  logic [WW-1:0]   w;
  logic [SHW-1:0]  wm1;
  logic [DW-1:0]   m;
  logic [DW-1:0]   a;
  logic [DW-1:0]   b;

  always_comb begin
    w = in_width;
    if (w == '0) w = WW'(1);
    if (w > WW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    wm1 = SHW'(w - WW'(1));
    m = (w >= WW'(DW)) ? '1 : ((DW'(1) << w) - DW'(1));
    a = in_lhs & m;
    b = in_rhs & m;
    item_c.op      = func_t'(in_func);
    item_c.a       = a;
    item_c.b       = b;
    item_c.m       = m;
    item_c.sg      = in_signed;
    item_c.sa      = (in_signed && a[wm1]) ? (a | ~m) : a;
    item_c.sb      = (in_signed && b[wm1]) ? (b | ~m) : b;
    item_c.rhs_nz  = (in_rhs != '0);
    item_c.amt_big = (in_rhs >= {{(DW-WW){1'b0}}, w});
    item_c.sh      = in_rhs[SHW-1:0];
  end

  assign in_ready = !v_r || fq_ready;
  assign fq_valid = v_r;
  assign fq_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) item_r <= item_c;
  end

endmodule

// ===== hdl/ialu_fifo.sv =====
// Short queue of classified items between front and back.
module ialu_fifo import ialu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  q_item_t push_item,
  output logic    q_valid,
  input  logic    pop,
  output q_item_t q_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t         mem_r [QDEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule

// ===== hdl/ialu_back.sv =====
// Back end: combinational operators, shared 32x32 multiplier and radix-2 divider.
module ialu_back import ialu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  q_item_t       q_item,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_result,
  output logic          out_one
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } st_t;

  st_t            st_r, st_nxt;
  logic [DW-1:0]  a_r, b_r, acc_r, rem_r, m_r;
  logic [SHW-1:0] cnt_r;
  logic           mul_r, mod_r, na_r, negq_r;
  logic           ov_r;
  logic [DW-1:0]  res_r;
  logic           one_r;

  q_item_t        h;
  logic [DW-1:0]  res;
  logic           one;
  logic           lt_ab, lt_ba;
  logic           is_mul, is_div, is_long, out_avail, ld_fin;
  logic [DW-1:0]  asr_v;
  logic           na, nb;
  logic [31:0]    mx, my;
  logic [DW-1:0]  prod;
  logic [DW:0]    rem_sh, diff;
  logic [DW-1:0]  fin_res;

  assign h = q_item;

  always_comb begin
    lt_ab = h.sg ? ($signed(h.sa) < $signed(h.sb)) : (h.sa < h.sb);
    lt_ba = h.sg ? ($signed(h.sb) < $signed(h.sa)) : (h.sb < h.sa);
    asr_v = DW'($signed(h.sa) >>> h.sh);
    res = '0;
    one = 1'b0;
    unique case (h.op)
      F_PLUS:  res = h.a;
      F_MINUS: res = '0 - h.a;
      F_LNOT:  begin res = DW'(h.a == '0); one = 1'b1; end
      F_BNOT:  res = ~h.a;
      F_RAND:  begin res = DW'(h.a == h.m); one = 1'b1; end
      F_RNAND: begin res = DW'(h.a != h.m); one = 1'b1; end
      F_ROR:   begin res = DW'(h.a != '0); one = 1'b1; end
      F_RNOR:  begin res = DW'(h.a == '0); one = 1'b1; end
      F_RXOR:  begin res = DW'(^h.a); one = 1'b1; end
      F_RXNOR: begin res = DW'(~^h.a); one = 1'b1; end
      F_ADD:   res = h.a + h.b;
      F_SUB:   res = h.a - h.b;
      F_MUL, F_DIV, F_MOD: res = '0; // long ops; zero divisor lands here
      F_EQ:    begin res = DW'(h.a == h.b); one = 1'b1; end
      F_NE:    begin res = DW'(h.a != h.b); one = 1'b1; end
      F_LT:    begin res = DW'(lt_ab); one = 1'b1; end
      F_LE:    begin res = DW'(!lt_ba); one = 1'b1; end
      F_GT:    begin res = DW'(lt_ba); one = 1'b1; end
      F_GE:    begin res = DW'(!lt_ab); one = 1'b1; end
      F_AND:   res = h.a & h.b;
      F_OR:    res = h.a | h.b;
      F_XOR:   res = h.a ^ h.b;
      F_XNOR:  res = ~(h.a ^ h.b);
      F_LAND:  begin res = DW'((h.a != '0) && h.rhs_nz); one = 1'b1; end
      F_LOR:   begin res = DW'((h.a != '0) || h.rhs_nz); one = 1'b1; end
      F_SHL:   res = h.amt_big ? '0 : (h.a << h.sh);
      F_LSR:   res = h.amt_big ? '0 : (h.a >> h.sh);
      F_ASR: begin
        if (h.sg && h.sa[DW-1]) res = h.amt_big ? '1 : asr_v;
        else res = h.amt_big ? '0 : (h.a >> h.sh);
      end
      default: begin res = '0; one = 1'b0; end
    endcase
    res = res & h.m;
  end

  assign is_mul    = (h.op == F_MUL);
  assign is_div    = ((h.op == F_DIV) || (h.op == F_MOD)) && (h.b != '0);
  assign is_long   = is_mul || is_div;
  assign out_avail = !ov_r || out_ready;
  assign q_pop     = (st_r == S_IDLE) && q_valid && (is_long || out_avail);
  assign ld_fin    = (st_r == S_FIN) && out_avail;
  assign na        = h.sg && h.sa[DW-1];
  assign nb        = h.sg && h.sb[DW-1];

  // partial products of the low 64 bits of a 64x64 product
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    begin mx = a_r[31:0];  my = b_r[31:0];  end
      2'd1:    begin mx = a_r[31:0];  my = b_r[63:32]; end
      default: begin mx = a_r[63:32]; my = b_r[31:0];  end
    endcase
    prod = DW'(mx) * DW'(my);
  end

  assign rem_sh = {rem_r, a_r[DW-1]};
  assign diff   = rem_sh - {1'b0, b_r};

  always_comb begin
    if (mul_r) fin_res = acc_r;
    else if (!mod_r) fin_res = negq_r ? ('0 - a_r) : a_r;
    else fin_res = na_r ? ('0 - rem_r) : rem_r;
    fin_res = fin_res & m_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_pop && is_mul) st_nxt = S_MUL;
              else if (q_pop && is_div) st_nxt = S_DIV;
      S_MUL:  if (cnt_r == SHW'(2)) st_nxt = S_FIN;
      S_DIV:  if (cnt_r == SHW'(DW - 1)) st_nxt = S_FIN;
      S_FIN:  if (out_avail) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if ((q_pop && !is_long) || ld_fin) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end

    if (q_pop && is_long) begin
      cnt_r  <= '0;
      mul_r  <= is_mul;
      mod_r  <= (h.op == F_MOD);
      na_r   <= na;
      negq_r <= na != nb;
      m_r    <= h.m;
      rem_r  <= '0;
      if (is_mul) begin
        a_r <= h.a;
        b_r <= h.b;
      end else begin
        a_r <= na ? ('0 - h.sa) : h.sa;
        b_r <= nb ? ('0 - h.sb) : h.sb;
      end
    end else if (st_r == S_MUL) begin
      cnt_r <= cnt_r + SHW'(1);
      if (cnt_r == '0) acc_r <= prod;
      else acc_r[DW-1:32] <= acc_r[DW-1:32] + prod[31:0];
    end else if (st_r == S_DIV) begin
      cnt_r <= cnt_r + SHW'(1);
      a_r   <= {a_r[DW-2:0], !diff[DW]};
      rem_r <= diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
    end

    if (q_pop && !is_long) begin
      res_r <= res;
      one_r <= one;
    end else if (ld_fin) begin
      res_r <= fin_res;
      one_r <= 1'b0;
    end
  end

  assign out_valid  = ov_r;
  assign out_result = res_r;
  assign out_one    = one_r;

endmodule

// ===== hdl/hdl_integer_operator_alu.sv =====
// Throughput: one beat per cycle for combinational operators while results are taken;
// multiply holds the back end for three 32x32 partial products, and divide/modulo
// iterates one quotient bit a cycle.
// A two-entry queue lets the front keep accepting while the back end iterates.
// Synchronous active-low reset empties the front register, the queue and the output register.
module hdl_integer_operator_alu import ialu_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic       clk,
  input  logic       rst_n,
  ialu_in_if.sink    in_bus,
  ialu_out_if.source out_bus
);

  logic    fq_valid, fq_ready, q_full, q_valid, q_pop;
  q_item_t fq_item, q_item;

  ialu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_func   (in_bus.func),
    .in_lhs    (in_bus.lhs_value),
    .in_rhs    (in_bus.rhs_value),
    .in_width  (in_bus.width),
    .in_signed (in_bus.signed_mode),
    .fq_valid  (fq_valid),
    .fq_ready  (fq_ready),
    .fq_item   (fq_item)
  );

  assign fq_ready = !q_full;

  ialu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_valid && !q_full),
    .full      (q_full),
    .push_item (fq_item),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .q_item    (q_item)
  );

  ialu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_result (out_bus.result),
    .out_one    (out_bus.is_one_bit)
  );

endmodule

// ===== tb/tb_hdl_integer_operator_alu.sv =====
// Testbench for the integer operator unit: random and directed beats checked against a predictor.
module tb_hdl_integer_operator_alu import ialu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] result;
    logic        is_one_bit;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int       errors;

    function automatic logic [63:0] mask_of(int w);
      return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] sext(logic [63:0] v, int w);
      logic [63:0] mk;
      mk = mask_of(w);
      v &= mk;
      if (w < 64 && v[w-1]) v |= ~mk;
      return v;
    endfunction

    function automatic alu_res_t evaluate(logic [4:0] fn, logic [63:0] lhs,
                                          logic [63:0] rhs, logic [6:0] wd,
                                          logic sgn);
      alu_res_t    r;
      int          w;
      logic [63:0] mk, a, b, sa, sb, ua, ub, res;
      logic        one, na, nb;
      w = (wd == 0) ? 1 : ((wd > 64) ? 64 : wd);
      mk = mask_of(w);
      a = lhs & mk;
      b = rhs & mk;
      sa = sgn ? sext(a, w) : a;
      sb = sgn ? sext(b, w) : b;
      res = '0;
      one = 1'b0;
      case (fn)
        F_PLUS:  res = a;
        F_MINUS: res = -a;
        F_LNOT:  begin res = 64'(a == 0); one = 1'b1; end
        F_BNOT:  res = ~a;
        F_RAND:  begin res = 64'(a == mk); one = 1'b1; end
        F_RNAND: begin res = 64'(a != mk); one = 1'b1; end
        F_ROR:   begin res = 64'(a != 0); one = 1'b1; end
        F_RNOR:  begin res = 64'(a == 0); one = 1'b1; end
        F_RXOR:  begin res = 64'(^a); one = 1'b1; end
        F_RXNOR: begin res = 64'(~^a); one = 1'b1; end
        F_ADD:   res = a + b;
        F_SUB:   res = a - b;
        F_MUL:   res = a * b;
        F_DIV, F_MOD: begin
          if (b == 0) res = '0;
          else if (!sgn) res = (fn == F_DIV) ? a / b : a % b;
          else begin
            na = sa[63];
            nb = sb[63];
            ua = na ? -sa : sa;
            ub = nb ? -sb : sb;
            if (fn == F_DIV) begin
              res = ua / ub;
              if (na != nb) res = -res;
            end else begin
              res = ua % ub;
              if (na) res = -res;
            end
          end
        end
        F_EQ: begin res = 64'(a == b); one = 1'b1; end
        F_NE: begin res = 64'(a != b); one = 1'b1; end
        F_LT: begin
          res = 64'(sgn ? ($signed(sa) < $signed(sb)) : (sa < sb)); one = 1'b1;
        end
        F_LE: begin
          res = 64'(sgn ? ($signed(sa) <= $signed(sb)) : (sa <= sb)); one = 1'b1;
        end
        F_GT: begin
          res = 64'(sgn ? ($signed(sa) > $signed(sb)) : (sa > sb)); one = 1'b1;
        end
        F_GE: begin
          res = 64'(sgn ? ($signed(sa) >= $signed(sb)) : (sa >= sb)); one = 1'b1;
        end
        F_AND:  res = a & b;
        F_OR:   res = a | b;
        F_XOR:  res = a ^ b;
        F_XNOR: res = ~(a ^ b);
        F_LAND: begin res = 64'((a != 0) && (rhs != 0)); one = 1'b1; end
        F_LOR:  begin res = 64'((a != 0) || (rhs != 0)); one = 1'b1; end
        F_SHL:  res = (rhs >= w) ? '0 : (a << rhs);
        F_LSR:  res = (rhs >= w) ? '0 : (a >> rhs);
        F_ASR: begin
          // kept out of a ?: so the shift stays signed
          if (sgn && sa[63]) begin
            if (rhs >= w) res = '1;
            else res = $signed(sa) >>> rhs;
          end else res = (rhs >= w) ? '0 : (a >> rhs);
        end
        default: begin res = '0; one = 1'b0; end
      endcase
      r.result = res & mk;
      r.is_one_bit = one;
      return r;
    endfunction

    function void note_operation(logic [4:0] fn, logic [63:0] lhs, logic [63:0] rhs,
                                 logic [6:0] wd, logic sgn);
      pending.push_back(evaluate(fn, lhs, rhs, wd, sgn));
    endfunction

    function void check_result(logic [63:0] res, logic one);
      alu_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h/%b", $time, res, one);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.result !== res) begin
        $display("%0t: result expected %h actual %h", $time, e.result, res);
        errors++;
      end
      if (e.is_one_bit !== one) begin
        $display("%0t: is_one_bit expected %b actual %b", $time, e.is_one_bit, one);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ialu_in_if  in_bus ();
  ialu_out_if out_bus ();
  alu_scoreboard board;
  bit stall_long;
  bit no_idle;

  hdl_integer_operator_alu dut (.clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // monitor at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        board.note_operation(in_bus.func, in_bus.lhs_value, in_bus.rhs_value,
                             in_bus.width, in_bus.signed_mode);
      if (out_bus.valid && out_bus.ready)
        board.check_result(out_bus.result, out_bus.is_one_bit);
    end
  end

  // receiver: random backpressure, or a long hold-off on request
  initial begin
    int n;
    out_bus.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_long) begin
        out_bus.ready <= 0;
        for (n = 0; n < 400; n++) @(negedge clk);
        stall_long = 0;
      end
      out_bus.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_operand(int w);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << (w - 1);
      3: return (64'd1 << (w - 1)) - 1;
      default: return rnd64();
    endcase
  endfunction

  task automatic send_op(logic [4:0] fn, logic [63:0] lhs, logic [63:0] rhs,
                         logic [6:0] wd, logic sgn);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_bus.valid <= 0;
      @(negedge clk);
    end
    in_bus.valid <= 1;
    in_bus.func <= fn;
    in_bus.lhs_value <= lhs;
    in_bus.rhs_value <= rhs;
    in_bus.width <= wd;
    in_bus.signed_mode <= sgn;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_random(int w_max);
    logic [4:0] fn;
    int w;
    logic [63:0] rhs;
    fn = 5'($urandom_range(31));
    // keep divide traffic lighter, it holds the back end long
    if ((fn == F_DIV || fn == F_MOD) && $urandom_range(2) != 0)
      fn = 5'($urandom_range(12));
    w = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, w_max);
    if ($urandom_range(9) == 0) w = $urandom_range(1) ? 0 : $urandom_range(65, 127);
    rhs = pick_operand((w < 1) ? 1 : (w > 64 ? 64 : w));
    if (fn >= F_SHL && fn <= F_ASR && $urandom_range(3) != 0)
      rhs = 64'($urandom_range(70));
    send_op(fn, pick_operand((w < 1) ? 1 : (w > 64 ? 64 : w)), rhs, 7'(w),
            1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_bus.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    int i;
    board = new();
    rst_n = 0;
    in_bus.valid = 0;
    in_bus.func = '0;
    in_bus.lhs_value = '0;
    in_bus.rhs_value = '0;
    in_bus.width = 7'd1;
    in_bus.signed_mode = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed corners
    send_op(F_DIV, 64'h8000_0000_0000_0000, '1, 7'd64, 1);
    send_op(F_DIV, 64'h80, 64'hFF, 7'd8, 1);
    send_op(F_MOD, 64'hF9, 64'h03, 7'd8, 1);
    send_op(F_DIV, 64'h1234, 64'h0, 7'd16, 0);
    send_op(F_MOD, 64'h1234, 64'h0, 7'd16, 1);
    send_op(F_ASR, 64'h80, 64'd9, 7'd8, 1);
    send_op(F_ASR, 64'h80, 64'd3, 7'd8, 1);
    send_op(F_ASR, 64'h80, 64'd3, 7'd8, 0);
    send_op(F_LSR, 64'h80, 64'd3, 7'd8, 1);
    send_op(F_SHL, '1, 64'd64, 7'd64, 0);
    send_op(F_SHL, '1, '1, 7'd64, 0);
    send_op(F_ADD, '1, 64'd1, 7'd0, 0);
    send_op(F_MUL, '1, '1, 7'd100, 1);
    send_op(F_LT, 64'h80, 64'h01, 7'd8, 1);
    send_op(F_LT, 64'h80, 64'h01, 7'd8, 0);
    send_op(F_LAND, 64'h1, 64'h100, 7'd8, 0);
    send_op(F_LOR, 64'h0, 64'h100, 7'd8, 0);
    send_op(5'd30, '1, '1, 7'd64, 1);
    send_op(5'd31, '1, '1, 7'd127, 0);
    for (i = 0; i <= 29; i += 5) send_op(5'(i), '1, '0, 7'd64, 1);

    // sender pauses until everything is back
    drain();

    // long receiver hold-off while items keep coming
    stall_long = 1;
    for (i = 0; i < 40; i++) send_random(16);
    drain();

    no_idle = 1;
    for (i = 0; i < 80; i++) send_random(64);
    no_idle = 0;
    for (i = 0; i < 330; i++) send_random((i % 4 == 0) ? 64 : 12);
    drain();
    repeat (100) @(negedge clk);

    if (board.errors == 0 && board.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ialu_pkg.sv
hdl/ialu_if.sv
hdl/ialu_front.sv
hdl/ialu_fifo.sv
hdl/ialu_back.sv
hdl/hdl_integer_operator_alu.sv
tb/tb_hdl_integer_operator_alu.sv
